>>> rtl/sis_pkg.sv
// Shared types, constants and the transition helper for the interlock supervisor.
package sis_pkg;

  typedef enum logic [3:0] {
    ST_BOOT      = 4'd0,
    ST_SELFCHECK = 4'd1,
    ST_STANDBY   = 4'd2,
    ST_OBSERVE   = 4'd3,
    ST_SCAN      = 4'd4,
    ST_DEGRADED  = 4'd5,
    ST_SUSPEND   = 4'd6,
    ST_SAFE      = 4'd7,
    ST_FAULT     = 4'd8
  } state_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_LINK    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_SENSOR  = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_OVERHEAT = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic signed [11:0] OVERHEAT_RST = 12'sd600;
  localparam logic [21:0]        TIMEOUT_RST  = 22'd30000;

  localparam logic [7:0] SERVO_MAX     = 8'd180;
  localparam logic [7:0] SCORE_SENSOR  = 8'd10;
  localparam logic [7:0] SCORE_SERVO   = 8'd15;
  localparam logic [7:0] SCORE_LINK    = 8'd20;
  localparam logic [7:0] SCORE_THERMAL = 8'd10;
  localparam logic [7:0] SCORE_MAX     = 8'd100;

  typedef struct packed {
    cmd_t                command;
    logic [31:0]         now_ms;
    logic [3:0]          target_state;
    logic                rain_seen;
    logic signed [11:0]  temperature;
    logic                climate_a_ok;
    logic                climate_b_ok;
    logic                light_sensor_ok;
    logic                rain_sensor_ok;
    logic signed [8:0]   pan_angle;
    logic signed [8:0]   tilt_angle;
    logic                backend_up;
  } item_t;

  typedef struct packed {
    state_t      present;
    state_t      prior;
    logic        lock;
    logic [31:0] last_contact;
    logic [6:0]  score;
    logic        link;
  } sup_state_t;

  typedef struct packed {
    logic signed [11:0] overheat_limit;
    logic [21:0]        link_timeout_ms;
  } cfg_t;

  typedef struct packed {
    state_t present;
    state_t prior;
    logic   changed;
    logic   park;
    logic   rejected;
  } ask_t;

  typedef struct packed {
    state_t     current_state;
    state_t     previous_state;
    logic       state_changed;
    logic       park_request;
    logic       request_rejected;
    logic       rain_lock;
    logic [6:0] health_score;
    logic       link_ok_flag;
    logic       observe_allowed;
  } result_t;

  function automatic logic is_park(logic [3:0] s);
    return (s == ST_SUSPEND) || (s == ST_SAFE) || (s == ST_FAULT);
  endfunction

  // One transition request: codes past fault and same-state requests do nothing,
  // the lock refuses anything but a park state.
  function automatic ask_t sis_ask(ask_t a, logic en, logic [3:0] tgt, logic lock);
    ask_t r;
    r = a;
    if (en && (tgt <= ST_FAULT) && (tgt != a.present)) begin
      if (lock && !is_park(tgt)) begin
        r.rejected = 1'b1;
      end else begin
        r.prior   = a.present;
        r.present = state_t'(tgt);
        r.changed = 1'b1;
        if (is_park(tgt)) begin
          r.park = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/sis_rules.sv
// Combinational rule evaluation: next supervisor state and result for one item.
module sis_rules
  import sis_pkg::*;
(
  input  item_t      item,
  input  sup_state_t st,
  input  cfg_t       cfg,
  output sup_state_t st_nxt,
  output result_t    res
);

  ask_t        a0, a1, a2;
  logic        en1, en2;
  logic [3:0]  t1, t2;
  logic        lock_n;
  logic [31:0] last_n;
  logic [6:0]  score_n;
  logic        link_n;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        overheat;
  logic        below_limit;
  logic        pan_in, tilt_in;
  logic [7:0]  sum;

  assign elapsed     = item.now_ms - st.last_contact;
  assign timed_out   = elapsed > {10'd0, cfg.link_timeout_ms};
  assign overheat    = item.temperature > cfg.overheat_limit;
  assign below_limit = item.temperature < cfg.overheat_limit;
  assign pan_in      = !item.pan_angle[8] && (item.pan_angle[7:0] <= SERVO_MAX);
  assign tilt_in     = !item.tilt_angle[8] && (item.tilt_angle[7:0] <= SERVO_MAX);

  always_comb begin
    sum = (item.climate_a_ok      ? SCORE_SENSOR  : 8'd0)
        + (item.climate_b_ok      ? SCORE_SENSOR  : 8'd0)
        + (item.light_sensor_ok   ? SCORE_SENSOR  : 8'd0)
        + (item.rain_sensor_ok    ? SCORE_SENSOR  : 8'd0)
        + (pan_in                 ? SCORE_SERVO   : 8'd0)
        + (tilt_in                ? SCORE_SERVO   : 8'd0)
        + (item.backend_up        ? SCORE_LINK    : 8'd0)
        + ((!lock_n && below_limit) ? SCORE_THERMAL : 8'd0);
  end

  always_comb begin
    lock_n  = st.lock;
    last_n  = st.last_contact;
    score_n = st.score;
    link_n  = st.link;
    en1     = 1'b0;
    t1      = ST_BOOT;
    en2     = 1'b0;
    t2      = ST_BOOT;
    a0      = '{present: st.present, prior: st.prior,
                changed: 1'b0, park: 1'b0, rejected: 1'b0};

    case (item.command)
      CMD_START: begin
        last_n = item.now_ms;
        en1    = 1'b1;
        t1     = ST_SELFCHECK;
      end
      CMD_LINK: begin
        last_n = item.now_ms;
      end
      CMD_REQUEST: begin
        en1 = 1'b1;
        t1  = item.target_state;
      end
      CMD_SENSOR: begin
        if (item.rain_seen) begin
          lock_n = 1'b1;
          en1    = (st.present != ST_SUSPEND) && (st.present != ST_FAULT);
          t1     = ST_SUSPEND;
        end else begin
          lock_n = 1'b0;
          en1    = st.lock && (st.present == ST_SUSPEND);
          t1     = ST_STANDBY;
        end
        score_n = (sum > SCORE_MAX) ? SCORE_MAX[6:0] : sum[6:0];
        link_n  = item.backend_up;
      end
      default: ;
    endcase

    a1 = sis_ask(a0, en1, t1, lock_n);

    // second rule stage sees the state after a possible rain release
    if ((item.command == CMD_SENSOR) && !item.rain_seen) begin
      if (overheat) begin
        en2 = 1'b1;
        t2  = ST_SAFE;
      end else if (timed_out && ((a1.present == ST_OBSERVE) || (a1.present == ST_SCAN))) begin
        en2 = 1'b1;
        t2  = ST_SAFE;
      end else if (!item.climate_a_ok && !item.climate_b_ok &&
                   (a1.present == ST_OBSERVE)) begin
        en2 = 1'b1;
        t2  = ST_DEGRADED;
      end
    end

    a2 = sis_ask(a1, en2, t2, lock_n);
  end

  always_comb begin
    st_nxt.present      = a2.present;
    st_nxt.prior        = a2.prior;
    st_nxt.lock         = lock_n;
    st_nxt.last_contact = last_n;
    st_nxt.score        = score_n;
    st_nxt.link         = link_n;

    res.current_state    = a2.present;
    res.previous_state   = a2.prior;
    res.state_changed    = a2.changed;
    res.park_request     = a2.park;
    res.request_rejected = a2.rejected;
    res.rain_lock        = lock_n;
    res.health_score     = score_n;
    res.link_ok_flag     = link_n;
    res.observe_allowed  = ((a2.present == ST_STANDBY) || (a2.present == ST_OBSERVE) ||
                            (a2.present == ST_SCAN)) && !lock_n;
  end

endmodule

>>> rtl/safety_interlock_supervisor_core.sv
// Top level of the safety interlock supervisor: input register, state, result register.
// Path to out_*: input register, then result register; the rule stage updates state at once.
// Throughput: one item per cycle unless out_tready stalls the result register.
// Reset (rst_n low, synchronous): pipeline empty, state boot/boot, rain lock off,
//   last contact 0, health score 100, link flag 0, limits 600 and 30000 ms.
// Configuration writes are taken every cycle (cfg_ready tied high).
module safety_interlock_supervisor_core
  import sis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [35:32] target_state, [36] rain_seen, [48:37] temperature,
  // [49] climate_a_ok, [50] climate_b_ok, [51] light_sensor_ok, [52] rain_sensor_ok,
  // [61:53] pan_angle, [70:62] tilt_angle, [71] backend_up
  input  logic [71:0] in_tdata,
  // [1:0] command
  input  logic [1:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] current_state, [7:4] previous_state, [8] state_changed, [9] park_request,
  // [10] request_rejected, [11] rain_lock, [18:12] health_score, [19] link_ok_flag,
  // [20] observe_allowed, [23:21] zero
  output logic [23:0] out_tdata,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [21:0] cfg_data
);

  // Pipeline control: the result register advances when empty or drained;
  // the input register takes a new item whenever it is empty or moving on.
  logic       adv;
  logic       s1_valid_r;
  item_t      s1_item_r;
  item_t      in_item;

  sup_state_t st_r, st_nxt;
  cfg_t       cfg_r;
  result_t    res, res_r;
  logic       out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv || !s1_valid_r;
  assign cfg_ready = 1'b1;

  assign in_item.command           = cmd_t'(in_tuser);
  assign in_item.now_ms            = in_tdata[31:0];
  assign in_item.target_state      = in_tdata[35:32];
  assign in_item.rain_seen         = in_tdata[36];
  assign in_item.temperature       = in_tdata[48:37];
  assign in_item.climate_a_ok      = in_tdata[49];
  assign in_item.climate_b_ok      = in_tdata[50];
  assign in_item.light_sensor_ok   = in_tdata[51];
  assign in_item.rain_sensor_ok    = in_tdata[52];
  assign in_item.pan_angle         = in_tdata[61:53];
  assign in_item.tilt_angle        = in_tdata[70:62];
  assign in_item.backend_up        = in_tdata[71];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overheat_limit  <= OVERHEAT_RST;
      cfg_r.link_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OVERHEAT: cfg_r.overheat_limit  <= cfg_data[11:0];
        CFG_TIMEOUT:  cfg_r.link_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  sis_rules u_rules (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // supervisor state moves only when its item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.present      <= ST_BOOT;
      st_r.prior        <= ST_BOOT;
      st_r.lock         <= 1'b0;
      st_r.last_contact <= 32'd0;
      st_r.score        <= SCORE_MAX[6:0];
      st_r.link         <= 1'b0;
    end else if (adv && s1_valid_r) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0,
                       res_r.observe_allowed,
                       res_r.link_ok_flag,
                       res_r.health_score,
                       res_r.rain_lock,
                       res_r.request_rejected,
                       res_r.park_request,
                       res_r.state_changed,
                       res_r.previous_state,
                       res_r.current_state};

endmodule

>>> rtl/sis_checker.sv
// Port-level checks on the supervisor's result stream, bound to the top level.
module sis_checker
  import sis_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic [3:0] cur, prev;
  logic       changed, park, rejected, lock, obs;

  assign cur      = out_tdata[3:0];
  assign prev     = out_tdata[7:4];
  assign changed  = out_tdata[8];
  assign park     = out_tdata[9];
  assign rejected = out_tdata[10];
  assign lock     = out_tdata[11];
  assign obs      = out_tdata[20];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && park |-> (cur == ST_SUSPEND) || (cur == ST_SAFE) || (cur == ST_FAULT))
    else $error("park request without a park state");

  a_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && changed |-> cur != prev)
    else $error("transition reported with equal states");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rejected |-> lock && !changed)
    else $error("rejection without rain lock or with a transition");

  a_observe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && obs |-> !lock &&
      ((cur == ST_STANDBY) || (cur == ST_OBSERVE) || (cur == ST_SCAN)))
    else $error("observe allowed in a wrong state or under rain lock");

endmodule

bind safety_interlock_supervisor_core sis_checker u_sis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/safety_interlock_supervisor_checker.sv
// Channel monitor, status predictor and result comparison for the interlock supervisor.
module safety_interlock_supervisor_checker
  import sis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [21:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTS_SENSOR  = 10;
  localparam int PTS_SERVO   = 15;
  localparam int PTS_LINK    = 20;
  localparam int PTS_THERMAL = 10;
  localparam int SCORE_CAP   = 100;
  localparam int SERVO_TOP   = 180;

  // shadow of the supervisor state and its limits
  state_t             st_now;
  state_t             st_prev;
  logic               lock;
  logic [31:0]        contact_ms;
  logic [6:0]         score;
  logic               link_up;
  logic signed [11:0] limit_c;
  logic [21:0]        timeout_c;

  // per-item transition flags
  logic chg;
  logic park;
  logic rej;

  result_t predicted_status_q[$];
  int      mismatches = 0;
  int      depth = 0;

  assign fail_count = mismatches;
  assign pending    = depth;

  function automatic logic parks(logic [3:0] s);
    return (s == ST_SUSPEND) || (s == ST_SAFE) || (s == ST_FAULT);
  endfunction

  function automatic void request_state(logic [3:0] tgt);
    if (tgt > ST_FAULT || tgt == st_now) return;
    if (lock && !parks(tgt)) begin
      rej = 1'b1;
      return;
    end
    st_prev = st_now;
    st_now  = state_t'(tgt);
    chg     = 1'b1;
    if (parks(tgt)) park = 1'b1;
  endfunction

  function automatic result_t predict_status(cmd_t cmd, logic [71:0] d);
    result_t     r;
    logic [31:0] now_ms;
    logic [31:0] elapsed;
    int          temp_v;
    int          lim_v;
    int          pan_v;
    int          tilt_v;
    int          pts;
    now_ms = d[31:0];
    chg  = 1'b0;
    park = 1'b0;
    rej  = 1'b0;
    case (cmd)
      CMD_START: begin
        contact_ms = now_ms;
        request_state(ST_SELFCHECK);
      end
      CMD_LINK: contact_ms = now_ms;
      CMD_REQUEST: request_state(d[35:32]);
      default: begin
        temp_v  = $signed(d[48:37]);
        lim_v   = limit_c;
        pan_v   = $signed(d[61:53]);
        tilt_v  = $signed(d[70:62]);
        elapsed = now_ms - contact_ms;
        // rules in priority order, rain first
        if (d[36]) begin
          lock = 1'b1;
          if (st_now != ST_SUSPEND && st_now != ST_FAULT) request_state(ST_SUSPEND);
        end else begin
          if (lock) begin
            lock = 1'b0;
            if (st_now == ST_SUSPEND) request_state(ST_STANDBY);
          end
          if (temp_v > lim_v) begin
            request_state(ST_SAFE);
          end else if (elapsed > {10'd0, timeout_c} &&
                       (st_now == ST_OBSERVE || st_now == ST_SCAN)) begin
            request_state(ST_SAFE);
          end else if (!d[49] && !d[50] && st_now == ST_OBSERVE) begin
            request_state(ST_DEGRADED);
          end
        end
        pts = 0;
        if (d[49]) pts += PTS_SENSOR;
        if (d[50]) pts += PTS_SENSOR;
        if (d[51]) pts += PTS_SENSOR;
        if (d[52]) pts += PTS_SENSOR;
        if (pan_v >= 0 && pan_v <= SERVO_TOP) pts += PTS_SERVO;
        if (tilt_v >= 0 && tilt_v <= SERVO_TOP) pts += PTS_SERVO;
        if (d[71]) pts += PTS_LINK;
        if (!lock && temp_v < lim_v) pts += PTS_THERMAL;
        if (pts > SCORE_CAP) pts = SCORE_CAP;
        score   = 7'(pts);
        link_up = d[71];
      end
    endcase
    r.current_state    = st_now;
    r.previous_state   = st_prev;
    r.state_changed    = chg;
    r.park_request     = park;
    r.request_rejected = rej;
    r.rain_lock        = lock;
    r.health_score     = score;
    r.link_ok_flag     = link_up;
    r.observe_allowed  = (st_now == ST_STANDBY || st_now == ST_OBSERVE ||
                          st_now == ST_SCAN) && !lock;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      st_now     = ST_BOOT;
      st_prev    = ST_BOOT;
      lock       = 1'b0;
      contact_ms = '0;
      score      = 7'd100;
      link_up    = 1'b0;
      limit_c    = 12'sd600;
      timeout_c  = 22'd30000;
      predicted_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OVERHEAT) limit_c = cfg_data[11:0];
        else timeout_c = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (predicted_status_q.size() == 0) begin
          $error("result 0x%h with no item outstanding", out_tdata);
          mismatches++;
        end else begin
          want = predicted_status_q.pop_front();
          check_field("current_state", want.current_state, out_tdata[3:0]);
          check_field("previous_state", want.previous_state, out_tdata[7:4]);
          check_field("state_changed", want.state_changed, out_tdata[8]);
          check_field("park_request", want.park_request, out_tdata[9]);
          check_field("request_rejected", want.request_rejected, out_tdata[10]);
          check_field("rain_lock", want.rain_lock, out_tdata[11]);
          check_field("health_score", want.health_score, out_tdata[18:12]);
          check_field("link_ok_flag", want.link_ok_flag, out_tdata[19]);
          check_field("observe_allowed", want.observe_allowed, out_tdata[20]);
          check_field("pad", 0, out_tdata[23:21]);
        end
      end
      if (in_tvalid && in_tready)
        predicted_status_q.push_back(predict_status(cmd_t'(in_tuser), in_tdata));
    end
    depth = predicted_status_q.size();
  end

endmodule

>>> sim/safety_interlock_supervisor_core_tb.sv
// Stimulus and verdict for the interlock supervisor core: directed cases, then random phases.
module safety_interlock_supervisor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sis_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  // two-register pipeline, so this drain wait covers anything still in flight
  localparam int DRAIN_CYCLES = 8;
  // several times the length of the slowest legal run
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [21:0] cfg_data;

  int fail_count;
  int pending;

  // handshake seen at the last rising edge, read back at the falling edge
  logic in_acc  = 1'b0;
  logic cfg_acc = 1'b0;

  // generator state: its own view of time, last contact and weather
  logic [31:0]        clock_ms       = '0;
  logic [31:0]        gen_contact_ms = '0;
  logic               wet            = 1'b0;
  int                 cur_limit      = 600;
  logic [21:0]        cur_timeout    = 22'd30000;
  logic               calm_in        = 1'b0;
  logic               calm_out       = 1'b0;
  int                 cycle_count    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  safety_interlock_supervisor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  safety_interlock_supervisor_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    in_acc  <= in_tvalid && in_tready;
    cfg_acc <= cfg_valid && cfg_ready;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("safety_interlock_supervisor_core regression: fail");
      $finish;
    end
  end

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [11:0] clamp12(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return 12'sh800;
    return 12'(v);
  endfunction

  // Every field random over its full width; also the filler for fields a
  // command does not use, so those bits toggle too.
  function automatic item_t noise_item();
    item_t it;
    it.command           = cmd_t'($urandom_range(0, 3));
    it.now_ms            = $urandom;
    it.target_state      = 4'($urandom);
    it.rain_seen         = 1'($urandom);
    it.temperature       = 12'($urandom);
    it.climate_a_ok      = 1'($urandom);
    it.climate_b_ok      = 1'($urandom);
    it.light_sensor_ok   = 1'($urandom);
    it.rain_sensor_ok    = 1'($urandom);
    it.pan_angle         = 9'($urandom);
    it.tilt_angle        = 9'($urandom);
    it.backend_up        = 1'($urandom);
    return it;
  endfunction

  function automatic item_t mk_cmd(cmd_t c, logic [31:0] now, logic [3:0] tgt);
    item_t it;
    it              = noise_item();
    it.command      = c;
    it.now_ms       = now;
    it.target_state = tgt;
    return it;
  endfunction

  // oks = {climate_a, climate_b, light, rain sensor}
  function automatic item_t mk_sensor(logic [31:0] now, logic rain,
                                      logic signed [11:0] temp, logic [3:0] oks,
                                      logic signed [8:0] pan, logic signed [8:0] tilt,
                                      logic net);
    item_t it;
    it                   = noise_item();
    it.command           = CMD_SENSOR;
    it.now_ms            = now;
    it.rain_seen         = rain;
    it.temperature       = temp;
    {it.climate_a_ok, it.climate_b_ok, it.light_sensor_ok, it.rain_sensor_ok} = oks;
    it.pan_angle         = pan;
    it.tilt_angle        = tilt;
    it.backend_up        = net;
    return it;
  endfunction

  // Time mostly creeps forward; some items land right on the link timeout
  // edge, some jump far or wrap.
  function automatic logic [31:0] step_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, 1500);
      6, 7: clock_ms = gen_contact_ms + {10'd0, cur_timeout} + $urandom_range(0, 2) - 1;
      8: clock_ms = clock_ms + $urandom;
      default: clock_ms = $urandom;
    endcase
    return clock_ms;
  endfunction

  // Plausible traffic: requests mostly aim at the operating states, rain comes
  // in spells, temperatures cluster just under the overheat limit.
  function automatic item_t shaped_item();
    item_t it;
    int    pick;
    int    lim;
    it        = noise_item();
    lim       = cur_limit;
    it.now_ms = step_time();
    pick      = $urandom_range(0, 99);
    if (pick < 8) begin
      it.command = CMD_START;
    end else if (pick < 18) begin
      it.command = CMD_LINK;
    end else if (pick < 45) begin
      it.command = CMD_REQUEST;
      pick = $urandom_range(0, 99);
      if (pick < 50) it.target_state = 4'($urandom_range(ST_STANDBY, ST_SCAN));
      else if (pick < 65) it.target_state = 4'($urandom_range(ST_SUSPEND, ST_FAULT));
      else if (pick < 75) it.target_state = 4'($urandom_range(9, 15));
      else it.target_state = 4'($urandom_range(ST_BOOT, ST_FAULT));
    end else begin
      it.command = CMD_SENSOR;
      if ($urandom_range(0, 11) == 0) wet = !wet;
      it.rain_seen = wet;
      case ($urandom_range(0, 9))
        7: it.temperature = clamp12(lim - 1 + int'($urandom_range(0, 2)));
        8: it.temperature = clamp12(lim + int'($urandom_range(1, 300)));
        9: ; // keep the full-range value
        default: it.temperature = clamp12(lim - int'($urandom_range(1, 300)));
      endcase
      if ($urandom_range(0, 11) == 0) begin
        it.climate_a_ok = 1'b0;
        it.climate_b_ok = 1'b0;
      end else begin
        it.climate_a_ok = $urandom_range(0, 7) != 0;
        it.climate_b_ok = $urandom_range(0, 7) != 0;
      end
      it.light_sensor_ok = $urandom_range(0, 7) != 0;
      it.rain_sensor_ok  = $urandom_range(0, 7) != 0;
      if ($urandom_range(0, 4) != 0) it.pan_angle = 9'($urandom_range(0, 180));
      if ($urandom_range(0, 4) != 0) it.tilt_angle = 9'($urandom_range(0, 180));
      it.backend_up = $urandom_range(0, 3) != 0;
    end
    return it;
  endfunction

  // Drive one item at a falling edge and hold it until a rising edge takes it.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic put_item(input item_t it);
    int idle;
    idle = calm_in ? 0 : pick_gap();
    if (idle > 0) begin
      in_tvalid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tdata  = {it.backend_up, it.tilt_angle, it.pan_angle, it.rain_sensor_ok,
                 it.light_sensor_ok, it.climate_b_ok, it.climate_a_ok, it.temperature,
                 it.rain_seen, it.target_state, it.now_ms};
    in_tuser  = it.command;
    in_tvalid = 1'b1;
    if (it.command == CMD_START || it.command == CMD_LINK) gen_contact_ms = it.now_ms;
    do @(negedge clk); while (!in_acc);
  endtask

  // Stop sending and wait until every result is out and the pipe is empty.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [21:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 29) == 0) begin
        // bring-up: start, standby, then observe or scan
        put_item(mk_cmd(CMD_START, step_time(), ST_BOOT));
        put_item(mk_cmd(CMD_REQUEST, step_time(), ST_STANDBY));
        put_item(mk_cmd(CMD_REQUEST, step_time(),
                        4'($urandom_range(ST_OBSERVE, ST_SCAN))));
        k += 3;
      end else begin
        put_item($urandom_range(0, 99) < 15 ? noise_item() : shaped_item());
        k++;
      end
    end
  endtask

  // One configuration setting, written while the block is idle, then traffic.
  // The overheat write carries junk above bit 11 to show it is ignored.
  task automatic run_phase(input int lim, input logic [21:0] tmo, input int n,
                           input logic quiet_in, input logic quiet_out);
    settle();
    cur_limit   = lim;
    cur_timeout = tmo;
    write_reg(CFG_OVERHEAT, {10'($urandom), 12'(lim)});
    write_reg(CFG_TIMEOUT, tmo);
    calm_in  = quiet_in;
    calm_out = quiet_out;
    run_random(n);
  endtask

  // Result side backpressure, re-decided at every falling edge.
  initial begin : sink
    int hold;
    hold       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if (!calm_out) hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_START;
    cfg_valid = 1'b0;
    cfg_index = CFG_OVERHEAT;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset limits: overheat 600, link timeout 30000 ms.
    // healthy update while still in boot, full score
    put_item(mk_sensor(32'd100, 1'b0, 12'sd599, 4'hF, 9'sd90, 9'sd90, 1'b1));
    // targets past fault are ignored, as is a request for the present state
    put_item(mk_cmd(CMD_REQUEST, 32'd200, 4'd9));
    put_item(mk_cmd(CMD_REQUEST, 32'd200, 4'd15));
    put_item(mk_cmd(CMD_REQUEST, 32'd200, ST_BOOT));
    put_item(mk_cmd(CMD_START, 32'd1000, ST_BOOT));
    put_item(mk_cmd(CMD_REQUEST, 32'd1100, ST_STANDBY));
    put_item(mk_cmd(CMD_REQUEST, 32'd1200, ST_OBSERVE));
    // silence exactly at the timeout and temperature exactly at the limit do
    // not fire; both climate sensors lost while observing -> degraded
    put_item(mk_sensor(32'd31000, 1'b0, 12'sd600, 4'h0, 9'sd0, 9'sd180, 1'b0));
    put_item(mk_cmd(CMD_REQUEST, 32'd31000, ST_SCAN));
    put_item(mk_cmd(CMD_LINK, 32'd31000, ST_BOOT));
    // one ms past the timeout while scanning -> safe; angle edges just outside
    put_item(mk_sensor(32'd61001, 1'b0, 12'sh800, 4'hF, -9'sd1, 9'sd181, 1'b1));
    put_item(mk_cmd(CMD_REQUEST, 32'd61001, ST_STANDBY));
    // rain wins over a hot reading: lock and suspend
    put_item(mk_sensor(32'd61002, 1'b1, 12'sd2047, 4'b1010, 9'sh100, 9'sd255, 1'b0));
    // lock refuses a non-park target; same state is not a refusal
    put_item(mk_cmd(CMD_REQUEST, 32'd61003, ST_OBSERVE));
    put_item(mk_cmd(CMD_REQUEST, 32'd61003, ST_SUSPEND));
    // rain clears while hot: suspend -> standby -> safe in one item
    put_item(mk_sensor(32'd61004, 1'b0, 12'sd601, 4'b0101, 9'sd180, 9'sd0, 1'b1));
    put_item(mk_cmd(CMD_REQUEST, 32'd61005, ST_OBSERVE));
    put_item(mk_sensor(32'd61006, 1'b1, 12'sd0, 4'hF, 9'sd255, 9'sh100, 1'b1));
    // park targets pass the lock
    put_item(mk_cmd(CMD_REQUEST, 32'd61007, ST_FAULT));
    // rain and its clearing leave fault alone
    put_item(mk_sensor(32'd61008, 1'b1, 12'sd0, 4'hF, 9'sd10, 9'sd10, 1'b1));
    put_item(mk_sensor(32'd61009, 1'b0, 12'sd0, 4'hF, 9'sd10, 9'sd10, 1'b1));
    // elapsed time across the 32-bit wrap
    put_item(mk_cmd(CMD_START, 32'hFFFF_FF00, ST_BOOT));
    put_item(mk_cmd(CMD_REQUEST, 32'hFFFF_FF10, ST_SCAN));
    put_item(mk_sensor(32'h0000_0100, 1'b0, 12'sd0, 4'hF, 9'sd0, 9'sd0, 1'b1));
    put_item(mk_sensor(32'hFFFF_FF00 + 32'd30001, 1'b0, 12'sd0, 4'hF, 9'sd0, 9'sd0, 1'b1));

    // Random phases over the limit extremes, with quiet stretches on each side.
    run_phase(1250, 22'd0, 220, 1'b0, 1'b0);
    run_phase(-400, 22'h3F_FFFF, 200, 1'b1, 1'b0);
    run_phase(2047, 22'd1000, 200, 1'b0, 1'b1);
    run_phase(-2048, 22'd5000, 80, 1'b1, 1'b1);
    run_phase(600, 22'd30000, 200, 1'b0, 1'b0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("safety_interlock_supervisor_core regression: pass");
    end else begin
      $display("safety_interlock_supervisor_core regression: fail");
    end
    $finish;
  end

endmodule
